### rtl/bir_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bir_pkg - shared types and constants for the bilinear image resizer
// Pixel and channel layout, operation codes, register indexes and the
// fixed-point widths used along the coordinate path.
// ----------------------------------------------------------------------------
package bir_pkg;

  localparam int CH_W    = 8;             // bits per colour channel
  localparam int CH_NUM  = 4;             // channels per pixel
  localparam int PIX_W   = CH_W * CH_NUM;
  localparam int ONE_W   = CH_W + 1;      // width of the weight 256 - f
  localparam int LERP_W  = 2 * CH_W + 1;  // weighted sum of two channels

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [CH_W-1:0]  frac_t;

  // input item fields
  localparam int WADDR_W = 16;
  localparam int DEST_W  = 12;

  // configuration fields
  localparam int SIZE_W  = 11;
  localparam int BASE_W  = 16;
  localparam int SCALE_W = 27;
  localparam int CFG_W   = 27;
  localparam int IDX_W   = 3;

  // 23.16 source position: destination times scale
  localparam int FRAC_W  = 16;
  localparam int POS_W   = DEST_W + SCALE_W;
  localparam logic [POS_W-1:0] HALF = POS_W'(32768);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_FRAME_BASE = 3'd2;
  localparam logic [IDX_W-1:0] REG_X_SCALE    = 3'd3;
  localparam logic [IDX_W-1:0] REG_Y_SCALE    = 3'd4;

endpackage
`default_nettype wire

### rtl/bilinear_image_resize.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_image_resize - bilinear resampler over a single-port pixel memory
// Write transactions store a pixel; sample transactions read the four
// neighbours of the scaled source position and return one blended pixel.
// ----------------------------------------------------------------------------
// A sample makes four neighbour reads and a write one access; the single memory
//   port serves one neighbour read or one write per cycle, but the last read
//   of a sample waits while the quad register is full and not being taken.
// Reset: clears pipeline valids and sets the registers to their defaults;
//   pixel memory is not cleared. MEM_DEPTH must be a power of two.
module bilinear_image_resize import bir_pkg::*; #(
  parameter int MEM_DEPTH = 65536,
  parameter int MAX_DIM   = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               operation,
  input  wire logic [WADDR_W-1:0] write_address,
  input  wire pixel_t             write_pixel,
  input  wire logic [DEST_W-1:0]  dest_x,
  input  wire logic [DEST_W-1:0]  dest_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pixel_t                  out_pixel,
  input  wire logic               cfg_we,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int XW = (MAX_DIM > 2) ? $clog2(MAX_DIM - 1) : 1;
  localparam int MW = (XW + DW > AW) ? XW + DW : AW;

  // configuration
  logic [SIZE_W-1:0]  src_width, src_height;
  logic [BASE_W-1:0]  frame_base;
  logic [SCALE_W-1:0] x_scale, y_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SIZE_W'(2);
      src_height <= SIZE_W'(2);
      frame_base <= '0;
      x_scale    <= SCALE_W'(65536);
      y_scale    <= SCALE_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[SIZE_W-1:0];
        REG_FRAME_BASE: frame_base <= cfg_data[BASE_W-1:0];
        REG_X_SCALE:    x_scale    <= cfg_data[SCALE_W-1:0];
        REG_Y_SCALE:    y_scale    <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0] w_eff, h_eff;
  logic [AW-1:0] w_addr;

  always_comb begin
    if (src_width < SIZE_W'(2))                w_eff = DW'(2);
    else if (32'(src_width) > 32'(MAX_DIM))    w_eff = DW'(MAX_DIM);
    else                                       w_eff = DW'(src_width);
    if (src_height < SIZE_W'(2))               h_eff = DW'(2);
    else if (32'(src_height) > 32'(MAX_DIM))   h_eff = DW'(MAX_DIM);
    else                                       h_eff = DW'(src_height);
  end

  assign w_addr = AW'(w_eff);

  // pipeline handshake
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_load, s2_load, s3_load, s4_load, s4_take;
  logic q_valid, q_take, s6_valid, s6_take;
  logic [1:0] rd_cnt;
  logic rd_issue, rd_last, q_room;
  logic rd_valid;
  logic [1:0] rd_idx;
  logic q_load;

  assign s4_load = s3_valid && (!s4_valid || s4_take);
  assign s3_load = s2_valid && (!s3_valid || s4_load);
  assign s2_load = s1_valid && (!s2_valid || s3_load);
  assign in_stall = s1_valid && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  // stage 1: scale multiply
  logic             s1_op;
  logic [AW-1:0]    s1_waddr;
  pixel_t           s1_pix;
  logic [POS_W-1:0] s1_px, s1_py;

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op    <= operation;
      s1_waddr <= AW'(write_address);
      s1_pix   <= write_pixel;
      s1_px    <= POS_W'(dest_x) * POS_W'(x_scale);
      s1_py    <= POS_W'(dest_y) * POS_W'(y_scale);
    end
  end

  // stage 2: subtract one half and clamp to [0, size-2]
  logic [POS_W-1:0] px_sub, py_sub, px_hi, py_hi, px_c, py_c;
  logic             s2_op;
  logic [AW-1:0]    s2_waddr;
  pixel_t           s2_pix;
  logic [XW-1:0]    s2_xi, s2_yi;
  frac_t            s2_fx, s2_fy;

  always_comb begin
    px_sub = (s1_px < HALF) ? '0 : s1_px - HALF;
    py_sub = (s1_py < HALF) ? '0 : s1_py - HALF;
    px_hi  = POS_W'(w_eff - DW'(2)) << FRAC_W;
    py_hi  = POS_W'(h_eff - DW'(2)) << FRAC_W;
    px_c   = (px_sub > px_hi) ? px_hi : px_sub;
    py_c   = (py_sub > py_hi) ? py_hi : py_sub;
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_op    <= s1_op;
      s2_waddr <= s1_waddr;
      s2_pix   <= s1_pix;
      s2_xi    <= px_c[FRAC_W +: XW];
      s2_yi    <= py_c[FRAC_W +: XW];
      s2_fx    <= px_c[FRAC_W-CH_W +: CH_W];
      s2_fy    <= py_c[FRAC_W-CH_W +: CH_W];
    end
  end

  // stage 3: row offset and column base
  logic [MW-1:0] yw_full;
  logic          s3_op;
  logic [AW-1:0] s3_waddr, s3_yw, s3_bx;
  pixel_t        s3_pix;
  frac_t         s3_fx, s3_fy;

  assign yw_full = MW'(s2_yi) * MW'(w_eff);

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_op    <= s2_op;
      s3_waddr <= s2_waddr;
      s3_pix   <= s2_pix;
      s3_yw    <= yw_full[AW-1:0];
      s3_bx    <= AW'(frame_base) + AW'(s2_xi);
      s3_fx    <= s2_fx;
      s3_fy    <= s2_fy;
    end
  end

  // stage 4: memory sequencer, one access per cycle unless the last read waits for the quad register
  logic          s4_op;
  logic [AW-1:0] s4_addr, rd_off, mem_addr;
  pixel_t        s4_pix;
  frac_t         s4_fx, s4_fy;
  logic          mem_we;

  always_ff @(posedge clk) begin
    if (s4_load) begin
      s4_op   <= s3_op;
      s4_addr <= (s3_op == OP_SAMPLE) ? s3_yw + s3_bx : s3_waddr;
      s4_pix  <= s3_pix;
      s4_fx   <= s3_fx;
      s4_fy   <= s3_fy;
    end
  end

  // the last neighbour read may only go out when the quad register is free
  assign q_room   = !q_valid || q_take;
  assign rd_last  = (rd_cnt == 2'd3);
  assign rd_issue = s4_valid && (s4_op == OP_SAMPLE) && (!rd_last || q_room);
  assign mem_we   = s4_valid && (s4_op == OP_WRITE);
  assign s4_take  = mem_we || (rd_issue && rd_last);

  always_comb begin
    case (rd_cnt)
      2'd0:    rd_off = '0;
      2'd1:    rd_off = AW'(1);
      2'd2:    rd_off = w_addr;
      2'd3:    rd_off = w_addr + AW'(1);
      default: rd_off = '0;
    endcase
  end

  assign mem_addr = mem_we ? s4_addr : s4_addr + rd_off;

  pixel_t mem [MEM_DEPTH];
  pixel_t rdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= s4_pix;
    else        rdata <= mem[mem_addr];
  end

  // collect neighbours as the reads return
  pixel_t c00, c10, c01;
  frac_t  rd_fx, rd_fy;
  pixel_t q00, q10, q01, q11;
  frac_t  q_fx, q_fy;

  assign q_load = rd_valid && (rd_idx == 2'd3);

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_idx <= rd_cnt;
      rd_fx  <= s4_fx;
      rd_fy  <= s4_fy;
    end
    if (rd_valid) begin
      case (rd_idx)
        2'd0:    c00 <= rdata;
        2'd1:    c10 <= rdata;
        2'd2:    c01 <= rdata;
        default: ;
      endcase
    end
    if (q_load) begin
      q00  <= c00;
      q10  <= c10;
      q01  <= c01;
      q11  <= rdata;
      q_fx <= rd_fx;
      q_fy <= rd_fy;
    end
  end

  // stage 6: horizontal blend; output: vertical blend
  pixel_t h_top, h_bot, v_pix;
  pixel_t s6_top, s6_bot;
  frac_t  s6_fy;

  assign s6_take = s6_valid && (!out_valid || !out_stall);
  assign q_take  = q_valid && (!s6_valid || s6_take);

  bir_lerp u_lerp_top (.px_a(q00), .px_b(q10), .frac(q_fx), .px_out(h_top));
  bir_lerp u_lerp_bot (.px_a(q01), .px_b(q11), .frac(q_fx), .px_out(h_bot));
  bir_lerp u_lerp_ver (.px_a(s6_top), .px_b(s6_bot), .frac(s6_fy), .px_out(v_pix));

  always_ff @(posedge clk) begin
    if (q_take) begin
      s6_top <= h_top;
      s6_bot <= h_bot;
      s6_fy  <= q_fy;
    end
    if (s6_take) out_pixel <= v_pix;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      rd_cnt    <= '0;
      rd_valid  <= 1'b0;
      q_valid   <= 1'b0;
      s6_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load)      s1_valid <= 1'b1;
      else if (s2_load) s1_valid <= 1'b0;
      if (s2_load)      s2_valid <= 1'b1;
      else if (s3_load) s2_valid <= 1'b0;
      if (s3_load)      s3_valid <= 1'b1;
      else if (s4_load) s3_valid <= 1'b0;
      if (s4_load)      s4_valid <= 1'b1;
      else if (s4_take) s4_valid <= 1'b0;
      // wraps to zero as the last read goes out
      if (rd_issue) rd_cnt <= rd_cnt + 2'd1;
      rd_valid <= rd_issue;
      if (q_load)      q_valid <= 1'b1;
      else if (q_take) q_valid <= 1'b0;
      if (q_take)       s6_valid <= 1'b1;
      else if (s6_take) s6_valid <= 1'b0;
      if (s6_take)         out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // the quad register is never reloaded over an unconsumed neighbour set
  a_quad_free: assert property (@(posedge clk) disable iff (rst)
    q_load |-> !q_valid)
    else $error("quad register overwritten while holding a sample");

  // a partial read sequence always belongs to a sample held in the sequencer
  a_rd_owner: assert property (@(posedge clk) disable iff (rst)
    (rd_cnt != 2'd0) |-> (s4_valid && s4_op == OP_SAMPLE))
    else $error("read counter running without a sample in the sequencer");

  // a blocked horizontal result holds until the output stage takes it
  a_s6_hold: assert property (@(posedge clk) disable iff (rst)
    (s6_valid && !s6_take) |=> (s6_valid && $stable(s6_top) && $stable(s6_bot)))
    else $error("horizontal blend stage lost or changed a held result");

  // writes and neighbour reads never share the memory port
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> !rd_valid)
    else $error("memory write and read issued in the same cycle");

endmodule
`default_nettype wire

### rtl/bir_lerp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bir_lerp - four-channel linear blend of two pixels
// Each channel gives (a * (256 - f) + b * f) >> 8, floored.
// ----------------------------------------------------------------------------
module bir_lerp import bir_pkg::*; (
  input  pixel_t px_a,
  input  pixel_t px_b,
  input  frac_t  frac,
  output pixel_t px_out
);

  logic [ONE_W-1:0]  weight_a;
  logic [LERP_W-1:0] acc;

  assign weight_a = ONE_W'(1 << CH_W) - ONE_W'(frac);

  always_comb begin
    px_out = '0;
    acc    = '0;
    for (int c = 0; c < CH_NUM; c++) begin
      acc = LERP_W'(px_a[c*CH_W +: CH_W]) * LERP_W'(weight_a)
          + LERP_W'(px_b[c*CH_W +: CH_W]) * LERP_W'(frac);
      px_out[c*CH_W +: CH_W] = acc[CH_W +: CH_W];
    end
  end

endmodule
`default_nettype wire
